// ----- hdl/fsp_pkg.sv -----
// Shared types and constants for the flow sensor frame parser.
package fsp_pkg;

    localparam int PAYLOAD_BYTES = 20;
    localparam int PAY_IDX_W     = $clog2(PAYLOAD_BYTES);
    localparam int CFG_IDX_W     = 3;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_START   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SYSTEM  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_MESSAGE = CFG_IDX_W'(3);

    localparam logic [7:0] START_RESET   = 8'hEF;
    localparam logic [7:0] DEVICE_RESET  = 8'h0F;
    localparam logic [7:0] SYSTEM_RESET  = 8'h00;
    localparam logic [7:0] MESSAGE_RESET = 8'h51;

    typedef enum logic [1:0] {
        EV_DECODE   = 2'd0,
        EV_LENGTH   = 2'd1,
        EV_CHECKSUM = 2'd2,
        EV_HEADER   = 2'd3
    } t_event;

    typedef enum logic [2:0] {
        PH_START    = 3'd0,
        PH_DEVICE   = 3'd1,
        PH_SYSTEM   = 3'd2,
        PH_MESSAGE  = 3'd3,
        PH_SEQUENCE = 3'd4,
        PH_LENGTH   = 3'd5,
        PH_PAYLOAD  = 3'd6,
        PH_CHECK    = 3'd7
    } t_phase;

    typedef struct packed {
        t_event             event_code;
        logic [31:0]        sensor_time;
        logic [31:0]        range_mm;
        logic [7:0]         range_strength;
        logic [7:0]         range_precision;
        logic [7:0]         range_status;
        logic signed [15:0] flow_x;
        logic signed [15:0] flow_y;
        logic [7:0]         flow_quality_level;
        logic [7:0]         flow_state;
        logic [7:0]         frame_sequence;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result data;
    } t_push;

endpackage

// ----- hdl/flow_sensor_frame_parser_top.sv -----
// Top level of the flow sensor frame parser.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | to block  | i_in_valid / o_in_stall   | i_rx_byte
//  out     | from block| o_out_valid / i_out_stall | o_event_code .. o_frame_sequence
//  cfg     | to block  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One byte per cycle while o_in_stall is low.
// A result is pushed into the result queue when its closing byte is taken, and moves from there into the output
// register when that register is empty or not stalled. o_in_stall rises while the two-entry result queue is full.
// Synchronous active-low reset; no clearing pass, cfg always ready.
module flow_sensor_frame_parser_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_rx_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_event_code,
    output logic [31:0]                   o_sensor_time,
    output logic [31:0]                   o_range_mm,
    output logic [7:0]                    o_range_strength,
    output logic [7:0]                    o_range_precision,
    output logic [7:0]                    o_range_status,
    output logic signed [15:0]            o_flow_x,
    output logic signed [15:0]            o_flow_y,
    output logic [7:0]                    o_flow_quality_level,
    output logic [7:0]                    o_flow_state,
    output logic [7:0]                    o_frame_sequence,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fsp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data
);

    fsp_pkg::t_push   push;
    fsp_pkg::t_result q_head;
    fsp_pkg::t_result result;
    logic             q_full;
    logic             q_valid;
    logic             pop;

    assign o_cfg_ready = 1'b1;

    fsp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_full      (q_full),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_in_stall  (o_in_stall),
        .o_push      (push)
    );

    fsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    fsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .i_out_stall (i_out_stall),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_result    (result)
    );

    assign o_event_code         = result.event_code;
    assign o_sensor_time        = result.sensor_time;
    assign o_range_mm           = result.range_mm;
    assign o_range_strength     = result.range_strength;
    assign o_range_precision    = result.range_precision;
    assign o_range_status       = result.range_status;
    assign o_flow_x             = result.flow_x;
    assign o_flow_y             = result.flow_y;
    assign o_flow_quality_level = result.flow_quality_level;
    assign o_flow_state         = result.flow_state;
    assign o_frame_sequence     = result.frame_sequence;

endmodule

// ----- hdl/fsp_front.sv -----
// Front end: byte parser, header, length and checksum checks, payload store, result build.
module fsp_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_full,
    input  logic [7:0]                   i_rx_byte,
    input  logic                         i_cfg_we,
    input  logic [fsp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                   i_cfg_data,
    output logic                         o_in_stall,
    output fsp_pkg::t_push               o_push
);

    fsp_pkg::t_phase r_phase, n_phase;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_count, n_count;
    logic [7:0] r_len, n_len;
    logic [7:0] r_seq, n_seq;
    logic [7:0] r_start, r_device, r_system, r_message;
    logic [7:0] r_store [fsp_pkg::PAYLOAD_BYTES];

    logic       accept;
    logic       hdr_ok;
    logic       store_we;
    logic [7:0] expect_byte;
    logic [7:0] count_inc;

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;
    assign count_inc  = r_count + 8'd1;

    always_comb begin
        case (r_phase)
            fsp_pkg::PH_DEVICE: expect_byte = r_device;
            fsp_pkg::PH_SYSTEM: expect_byte = r_system;
            default:            expect_byte = r_message;
        endcase
    end
    assign hdr_ok = (i_rx_byte == expect_byte);

    // next state
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            case (r_phase)
                fsp_pkg::PH_START: begin
                    if (i_rx_byte == r_start) n_phase = fsp_pkg::PH_DEVICE;
                end
                fsp_pkg::PH_DEVICE:   n_phase = hdr_ok ? fsp_pkg::PH_SYSTEM : fsp_pkg::PH_START;
                fsp_pkg::PH_SYSTEM:   n_phase = hdr_ok ? fsp_pkg::PH_MESSAGE : fsp_pkg::PH_START;
                fsp_pkg::PH_MESSAGE:  n_phase = hdr_ok ? fsp_pkg::PH_SEQUENCE : fsp_pkg::PH_START;
                fsp_pkg::PH_SEQUENCE: n_phase = fsp_pkg::PH_LENGTH;
                fsp_pkg::PH_LENGTH: begin
                    n_phase = (i_rx_byte != 8'd0) ? fsp_pkg::PH_PAYLOAD : fsp_pkg::PH_CHECK;
                end
                fsp_pkg::PH_PAYLOAD: begin
                    if (count_inc >= r_len) n_phase = fsp_pkg::PH_CHECK;
                end
                fsp_pkg::PH_CHECK: n_phase = fsp_pkg::PH_START;
                default:           n_phase = fsp_pkg::PH_START;
            endcase
        end
    end

    // outputs and datapath
    always_comb begin
        n_sum    = r_sum;
        n_count  = r_count;
        n_len    = r_len;
        n_seq    = r_seq;
        store_we = 1'b0;
        o_push   = '0;
        if (accept) begin
            case (r_phase)
                fsp_pkg::PH_START: begin
                    if (i_rx_byte == r_start) n_sum = i_rx_byte;
                end
                fsp_pkg::PH_DEVICE, fsp_pkg::PH_SYSTEM, fsp_pkg::PH_MESSAGE: begin
                    if (hdr_ok) begin
                        n_sum = r_sum + i_rx_byte;
                    end else begin
                        n_sum                  = '0;
                        n_count                = '0;
                        n_len                  = '0;
                        o_push.valid           = 1'b1;
                        o_push.data.event_code = fsp_pkg::EV_HEADER;
                    end
                end
                fsp_pkg::PH_SEQUENCE: begin
                    n_seq = i_rx_byte;
                    n_sum = r_sum + i_rx_byte;
                end
                fsp_pkg::PH_LENGTH: begin
                    n_len   = i_rx_byte;
                    n_sum   = r_sum + i_rx_byte;
                    n_count = '0;
                end
                fsp_pkg::PH_PAYLOAD: begin
                    store_we = (r_count < 8'(fsp_pkg::PAYLOAD_BYTES));
                    n_sum    = r_sum + i_rx_byte;
                    n_count  = count_inc;
                end
                fsp_pkg::PH_CHECK: begin
                    n_sum                      = '0;
                    n_count                    = '0;
                    n_len                      = '0;
                    o_push.valid               = 1'b1;
                    o_push.data.frame_sequence = r_seq;
                    if (i_rx_byte != r_sum) begin
                        o_push.data.event_code = fsp_pkg::EV_CHECKSUM;
                    end else if (r_len != 8'(fsp_pkg::PAYLOAD_BYTES)) begin
                        o_push.data.event_code = fsp_pkg::EV_LENGTH;
                    end else begin
                        o_push.data.event_code         = fsp_pkg::EV_DECODE;
                        o_push.data.sensor_time        = {r_store[3], r_store[2],
                                                          r_store[1], r_store[0]};
                        o_push.data.range_mm           = {r_store[7], r_store[6],
                                                          r_store[5], r_store[4]};
                        o_push.data.range_strength     = r_store[8];
                        o_push.data.range_precision    = r_store[9];
                        o_push.data.range_status       = r_store[10];
                        o_push.data.flow_x             = {r_store[13], r_store[12]};
                        o_push.data.flow_y             = {r_store[15], r_store[14]};
                        o_push.data.flow_quality_level = r_store[16];
                        o_push.data.flow_state         = r_store[17];
                    end
                end
                default: begin
                    n_sum = r_sum;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= fsp_pkg::PH_START;
            r_sum     <= '0;
            r_count   <= '0;
            r_len     <= '0;
            r_seq     <= '0;
            r_start   <= fsp_pkg::START_RESET;
            r_device  <= fsp_pkg::DEVICE_RESET;
            r_system  <= fsp_pkg::SYSTEM_RESET;
            r_message <= fsp_pkg::MESSAGE_RESET;
        end else begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_count <= n_count;
            r_len   <= n_len;
            r_seq   <= n_seq;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    fsp_pkg::REG_START:   r_start   <= i_cfg_data;
                    fsp_pkg::REG_DEVICE:  r_device  <= i_cfg_data;
                    fsp_pkg::REG_SYSTEM:  r_system  <= i_cfg_data;
                    fsp_pkg::REG_MESSAGE: r_message <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_count[fsp_pkg::PAY_IDX_W-1:0]] <= i_rx_byte;
        end
    end

endmodule

// ----- hdl/fsp_queue.sv -----
// Short result queue between parser front end and output stage.
module fsp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fsp_pkg::t_push   i_push,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output fsp_pkg::t_result o_head
);

    fsp_pkg::t_result               r_mem [fsp_pkg::QUEUE_DEPTH];
    logic [fsp_pkg::QPTR_W-1:0]     r_wr_ptr, r_rd_ptr;
    logic [fsp_pkg::QCNT_W-1:0]     r_count;
    logic                           do_pop;

    assign o_full  = (r_count == fsp_pkg::QCNT_W'(fsp_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)       r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push.valid, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) r_mem[r_wr_ptr] <= i_push.data;
    end

endmodule

// ----- hdl/fsp_back.sv -----
// Output stage: pulls results from the queue into the output register.
module fsp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  fsp_pkg::t_result i_q_head,
    input  logic             i_out_stall,
    output logic             o_pop,
    output logic             o_out_valid,
    output fsp_pkg::t_result o_result
);

    logic             r_valid;
    fsp_pkg::t_result r_result;

    assign o_pop       = i_q_valid && (!r_valid || !i_out_stall);
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_out_stall) begin
            r_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_result <= i_q_head;
    end

endmodule

// ----- hdl/fsp_checker.sv -----
// Port-level checker for the flow sensor frame parser, bound to the top level.
module fsp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [1:0]         o_event_code,
    input logic [31:0]        o_sensor_time,
    input logic [31:0]        o_range_mm,
    input logic [7:0]         o_range_strength,
    input logic [7:0]         o_range_precision,
    input logic [7:0]         o_range_status,
    input logic signed [15:0] o_flow_x,
    input logic signed [15:0] o_flow_y,
    input logic [7:0]         o_flow_quality_level,
    input logic [7:0]         o_flow_state,
    input logic [7:0]         o_frame_sequence
);

    logic payload_zero;

    assign payload_zero = (o_sensor_time == '0) && (o_range_mm == '0)
                       && (o_range_strength == '0) && (o_range_precision == '0)
                       && (o_range_status == '0) && (o_flow_x == '0) && (o_flow_y == '0)
                       && (o_flow_quality_level == '0) && (o_flow_state == '0);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output transfer dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable({o_event_code, o_sensor_time, o_range_mm,
            o_flow_x, o_flow_y, o_frame_sequence}))
        else $error("stalled output changed");

    a_header_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_code == fsp_pkg::EV_HEADER)
            |-> payload_zero && (o_frame_sequence == '0))
        else $error("header error carries data");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_event_code == fsp_pkg::EV_LENGTH)
                     || (o_event_code == fsp_pkg::EV_CHECKSUM)) |-> payload_zero)
        else $error("undecoded frame carries payload");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind flow_sensor_frame_parser_top fsp_checker u_fsp_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_out_valid          (o_out_valid),
    .i_out_stall          (i_out_stall),
    .o_event_code         (o_event_code),
    .o_sensor_time        (o_sensor_time),
    .o_range_mm           (o_range_mm),
    .o_range_strength     (o_range_strength),
    .o_range_precision    (o_range_precision),
    .o_range_status       (o_range_status),
    .o_flow_x             (o_flow_x),
    .o_flow_y             (o_flow_y),
    .o_flow_quality_level (o_flow_quality_level),
    .o_flow_state         (o_flow_state),
    .o_frame_sequence     (o_frame_sequence)
);

// ----- tb/testbench.sv -----
// Testbench for the flow sensor frame parser: predicted reports checked on directed and random byte streams.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT    = 500;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 8;
    localparam int RANDOM_BYTES  = 800;

    typedef enum int {
        FRAME_OK,
        FRAME_BAD_SUM,
        FRAME_BAD_DEVICE,
        FRAME_BAD_SYSTEM,
        FRAME_BAD_MESSAGE
    } t_flaw;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic [7:0]                    rx_byte   = '0;
    logic                          out_stall = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic [fsp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]                    cfg_data  = '0;

    logic                 in_stall;
    logic                 out_valid;
    logic [1:0]           ev_code;
    logic [31:0]          sensor_time;
    logic [31:0]          range_mm;
    logic [7:0]           range_strength;
    logic [7:0]           range_precision;
    logic [7:0]           range_status;
    logic signed [15:0]   flow_x;
    logic signed [15:0]   flow_y;
    logic [7:0]           flow_quality_level;
    logic [7:0]           flow_state;
    logic [7:0]           frame_sequence;
    logic                 cfg_ready;

    // expected register contents
    logic [7:0] cfg_start   = fsp_pkg::START_RESET;
    logic [7:0] cfg_device  = fsp_pkg::DEVICE_RESET;
    logic [7:0] cfg_system  = fsp_pkg::SYSTEM_RESET;
    logic [7:0] cfg_message = fsp_pkg::MESSAGE_RESET;

    // parser state mirror
    fsp_pkg::t_phase rx_phase  = fsp_pkg::PH_START;
    logic [7:0] frame_sum = '0;
    logic [7:0] pay_count = '0;
    logic [7:0] pay_length = '0;
    logic [7:0] frame_seq = '0;
    logic [7:0] pay_store [fsp_pkg::PAYLOAD_BYTES];

    logic [7:0]       rx_bytes [$];
    fsp_pkg::t_result pending_reports [$];

    int fail_count    = 0;
    int queued_total  = 0;
    int sent_count    = 0;
    int taken_count   = 0;
    int reports_seen  = 0;
    int reports_drawn = 0;
    int gap_left      = 0;
    int stall_left    = 0;
    int send_gap_max  = 10;
    int stall_max     = 10;
    int idle_cycles   = 0;

    flow_sensor_frame_parser_top dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .o_in_stall           (in_stall),
        .i_rx_byte            (rx_byte),
        .o_out_valid          (out_valid),
        .i_out_stall          (out_stall),
        .o_event_code         (ev_code),
        .o_sensor_time        (sensor_time),
        .o_range_mm           (range_mm),
        .o_range_strength     (range_strength),
        .o_range_precision    (range_precision),
        .o_range_status       (range_status),
        .o_flow_x             (flow_x),
        .o_flow_y             (flow_y),
        .o_flow_quality_level (flow_quality_level),
        .o_flow_state         (flow_state),
        .o_frame_sequence     (frame_sequence),
        .i_cfg_valid          (cfg_valid),
        .o_cfg_ready          (cfg_ready),
        .i_cfg_index          (cfg_index),
        .i_cfg_data           (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic apply_register(input logic [fsp_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [7:0] data);
        case (idx)
            fsp_pkg::REG_START:   cfg_start   = data;
            fsp_pkg::REG_DEVICE:  cfg_device  = data;
            fsp_pkg::REG_SYSTEM:  cfg_system  = data;
            fsp_pkg::REG_MESSAGE: cfg_message = data;
            default: ;
        endcase
    endtask

    task automatic restart_frame();
        rx_phase   = fsp_pkg::PH_START;
        frame_sum  = '0;
        pay_count  = '0;
        pay_length = '0;
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        fsp_pkg::t_result rep;
        logic [7:0]       want;
        logic             sum_ok;
        rep = '0;
        case (rx_phase)
            fsp_pkg::PH_START: begin
                if (b == cfg_start) begin
                    frame_sum = b;
                    rx_phase  = fsp_pkg::PH_DEVICE;
                end
            end
            fsp_pkg::PH_DEVICE, fsp_pkg::PH_SYSTEM, fsp_pkg::PH_MESSAGE: begin
                want = (rx_phase == fsp_pkg::PH_DEVICE) ? cfg_device :
                       (rx_phase == fsp_pkg::PH_SYSTEM) ? cfg_system : cfg_message;
                if (b != want) begin
                    restart_frame();
                    rep.event_code = fsp_pkg::EV_HEADER;
                    pending_reports.push_back(rep);
                end else begin
                    frame_sum = frame_sum + b;
                    rx_phase  = fsp_pkg::t_phase'(rx_phase + 3'd1);
                end
            end
            fsp_pkg::PH_SEQUENCE: begin
                frame_seq = b;
                frame_sum = frame_sum + b;
                rx_phase  = fsp_pkg::PH_LENGTH;
            end
            fsp_pkg::PH_LENGTH: begin
                pay_length = b;
                frame_sum  = frame_sum + b;
                pay_count  = '0;
                rx_phase   = (b != 8'd0) ? fsp_pkg::PH_PAYLOAD : fsp_pkg::PH_CHECK;
            end
            fsp_pkg::PH_PAYLOAD: begin
                if (pay_count < fsp_pkg::PAYLOAD_BYTES)
                    pay_store[pay_count] = b;
                frame_sum = frame_sum + b;
                pay_count = pay_count + 8'd1;
                if (pay_count >= pay_length)
                    rx_phase = fsp_pkg::PH_CHECK;
            end
            default: begin
                sum_ok = (b == frame_sum);
                rep.frame_sequence = frame_seq;
                if (!sum_ok) begin
                    rep.event_code = fsp_pkg::EV_CHECKSUM;
                end else if (pay_length != fsp_pkg::PAYLOAD_BYTES) begin
                    rep.event_code = fsp_pkg::EV_LENGTH;
                end else begin
                    rep.event_code         = fsp_pkg::EV_DECODE;
                    rep.sensor_time        = {pay_store[3], pay_store[2],
                                              pay_store[1], pay_store[0]};
                    rep.range_mm           = {pay_store[7], pay_store[6],
                                              pay_store[5], pay_store[4]};
                    rep.range_strength     = pay_store[8];
                    rep.range_precision    = pay_store[9];
                    rep.range_status       = pay_store[10];
                    rep.flow_x             = {pay_store[13], pay_store[12]};
                    rep.flow_y             = {pay_store[15], pay_store[14]};
                    rep.flow_quality_level = pay_store[16];
                    rep.flow_state         = pay_store[17];
                end
                restart_frame();
                pending_reports.push_back(rep);
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    task automatic compare_report(input fsp_pkg::t_result want, input fsp_pkg::t_result got);
        check_field("event_code", want.event_code, got.event_code);
        check_field("sensor_time", want.sensor_time, got.sensor_time);
        check_field("range_mm", want.range_mm, got.range_mm);
        check_field("range_strength", want.range_strength, got.range_strength);
        check_field("range_precision", want.range_precision, got.range_precision);
        check_field("range_status", want.range_status, got.range_status);
        check_field("flow_x", want.flow_x, got.flow_x);
        check_field("flow_y", want.flow_y, got.flow_y);
        check_field("flow_quality_level", want.flow_quality_level, got.flow_quality_level);
        check_field("flow_state", want.flow_state, got.flow_state);
        check_field("frame_sequence", want.frame_sequence, got.frame_sequence);
    endtask

    // input transfers feed the predictor
    always @(posedge clk) begin
        if (rst_n && in_valid && in_stall === 1'b0) begin
            taken_count++;
            parse_rx_byte(rx_byte);
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && taken_count != sent_count) begin
            // stalled, hold the byte
        end else if (gap_left > 0) begin
            in_valid <= 1'b0;
            gap_left--;
        end else if (rx_bytes.size() > 0) begin
            rx_byte  <= rx_bytes.pop_front();
            in_valid <= 1'b1;
            sent_count++;
            gap_left = $urandom_range(0, send_gap_max);
        end else begin
            in_valid <= 1'b0;
        end
    end

    always @(posedge clk) begin : report_monitor
        fsp_pkg::t_result got;
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            reports_seen++;
            got.event_code         = fsp_pkg::t_event'(ev_code);
            got.sensor_time        = sensor_time;
            got.range_mm           = range_mm;
            got.range_strength     = range_strength;
            got.range_precision    = range_precision;
            got.range_status       = range_status;
            got.flow_x             = flow_x;
            got.flow_y             = flow_y;
            got.flow_quality_level = flow_quality_level;
            got.flow_state         = flow_state;
            got.frame_sequence     = frame_sequence;
            if (pending_reports.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected report, expected none, actual event %0d",
                         $time, ev_code);
            end else begin
                compare_report(pending_reports.pop_front(), got);
            end
        end
    end

    always @(negedge clk) begin
        if (reports_drawn != reports_seen) begin
            reports_drawn = reports_seen;
            stall_left    = $urandom_range(0, stall_max);
        end
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
                (cfg_valid && cfg_ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    task automatic write_register(input logic [fsp_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [7:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        apply_register(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (rx_bytes.size() != 0 || taken_count != sent_count || pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_byte(input logic [7:0] b);
        rx_bytes.push_back(b);
        queued_total++;
    endtask

    function automatic logic [7:0] wrong_byte(input logic [7:0] want);
        logic [7:0] r;
        if ($urandom_range(0, 1) == 1 && cfg_start != want)
            return cfg_start;
        do
            r = 8'($urandom_range(0, 255));
        while (r == want);
        return r;
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] r;
        do
            r = 8'($urandom_range(0, 255));
        while (r == cfg_start);
        return r;
    endfunction

    // fill < 0 gives a random payload
    task automatic queue_frame(input logic [7:0] seq, input int len, input t_flaw flaw,
                               input int fill);
        logic [7:0] sum;
        logic [7:0] b;
        int         k;
        push_byte(cfg_start);
        sum = cfg_start;
        if (flaw == FRAME_BAD_DEVICE) begin
            push_byte(wrong_byte(cfg_device));
            return;
        end
        push_byte(cfg_device);
        sum = sum + cfg_device;
        if (flaw == FRAME_BAD_SYSTEM) begin
            push_byte(wrong_byte(cfg_system));
            return;
        end
        push_byte(cfg_system);
        sum = sum + cfg_system;
        if (flaw == FRAME_BAD_MESSAGE) begin
            push_byte(wrong_byte(cfg_message));
            return;
        end
        push_byte(cfg_message);
        sum = sum + cfg_message;
        push_byte(seq);
        sum = sum + seq;
        push_byte(8'(len));
        sum = sum + 8'(len);
        for (k = 0; k < len; k++) begin
            b = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
            push_byte(b);
            sum = sum + b;
        end
        if (flaw == FRAME_BAD_SUM)
            sum = sum + 8'($urandom_range(1, 255));
        push_byte(sum);
    endtask

    task automatic queue_random_traffic(input int budget);
        int    stop_at;
        int    r;
        int    len;
        int    k;
        stop_at = queued_total + budget;
        while (queued_total < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                queue_frame(8'($urandom_range(0, 255)), fsp_pkg::PAYLOAD_BYTES, FRAME_OK, -1);
            end else if (r < 65) begin
                len = ($urandom_range(0, 39) == 0) ? 255 : $urandom_range(0, 30);
                queue_frame(8'($urandom_range(0, 255)), len, FRAME_OK, -1);
            end else if (r < 75) begin
                len = ($urandom_range(0, 1) == 1) ? fsp_pkg::PAYLOAD_BYTES
                                                  : $urandom_range(0, 30);
                queue_frame(8'($urandom_range(0, 255)), len, FRAME_BAD_SUM, -1);
            end else if (r < 85) begin
                queue_frame(8'($urandom_range(0, 255)), fsp_pkg::PAYLOAD_BYTES,
                            t_flaw'($urandom_range(FRAME_BAD_DEVICE, FRAME_BAD_MESSAGE)), -1);
            end else if (r < 95) begin
                len = $urandom_range(1, 4);
                for (k = 0; k < len; k++)
                    push_byte(noise_byte());
            end else begin
                push_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic configure(input int phase);
        logic [7:0] vals [4];
        int         k;
        case (phase % 4)
            0: vals = '{8'h00, 8'h00, 8'h00, 8'h00};
            1: vals = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
            2: vals = '{fsp_pkg::START_RESET, fsp_pkg::DEVICE_RESET,
                        fsp_pkg::SYSTEM_RESET, fsp_pkg::MESSAGE_RESET};
            default: begin
                for (k = 0; k < 4; k++)
                    vals[k] = 8'($urandom_range(0, 255));
            end
        endcase
        if (phase >= 4)
            for (k = 0; k < 4; k++)
                vals[k] = 8'($urandom_range(0, 255));
        write_register(fsp_pkg::REG_START, vals[0]);
        write_register(fsp_pkg::REG_DEVICE, vals[1]);
        write_register(fsp_pkg::REG_SYSTEM, vals[2]);
        write_register(fsp_pkg::REG_MESSAGE, vals[3]);
        // unused index, must be ignored
        write_register(fsp_pkg::REG_MESSAGE + 3'd1 + 3'($urandom_range(0, 3)),
                       8'($urandom_range(0, 255)));
        case (phase % 4)
            0: begin send_gap_max = 0;  stall_max = 0;  end
            1: begin send_gap_max = 10; stall_max = 10; end
            2: begin send_gap_max = 0;  stall_max = 10; end
            default: begin send_gap_max = 10; stall_max = 0; end
        endcase
    endtask

    initial begin : stimulus
        int phase;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h12);
        queue_frame(8'h00, fsp_pkg::PAYLOAD_BYTES, FRAME_OK, 8'h00);
        queue_frame(8'hFF, fsp_pkg::PAYLOAD_BYTES, FRAME_OK, 8'hFF);
        queue_frame(8'h5A, fsp_pkg::PAYLOAD_BYTES, FRAME_OK, -1);
        queue_frame(8'h01, 0, FRAME_OK, -1);
        queue_frame(8'h02, 1, FRAME_OK, -1);
        queue_frame(8'h03, fsp_pkg::PAYLOAD_BYTES - 1, FRAME_OK, -1);
        queue_frame(8'h04, fsp_pkg::PAYLOAD_BYTES + 1, FRAME_OK, -1);
        queue_frame(8'h05, 255, FRAME_OK, -1);
        queue_frame(8'h06, fsp_pkg::PAYLOAD_BYTES, FRAME_BAD_SUM, -1);
        queue_frame(8'h07, 0, FRAME_BAD_SUM, -1);
        queue_frame(8'h08, 255, FRAME_BAD_SUM, -1);
        queue_frame(8'h09, fsp_pkg::PAYLOAD_BYTES, FRAME_BAD_DEVICE, -1);
        queue_frame(8'h0A, fsp_pkg::PAYLOAD_BYTES, FRAME_BAD_SYSTEM, -1);
        queue_frame(8'h0B, fsp_pkg::PAYLOAD_BYTES, FRAME_BAD_MESSAGE, -1);
        // start byte repeated: the second one fails as device and is not retried
        push_byte(cfg_start);
        push_byte(cfg_start);
        queue_frame(8'h0C, fsp_pkg::PAYLOAD_BYTES, FRAME_OK, -1);
        wait_idle();

        for (phase = 0; phase < PHASES; phase++) begin
            configure(phase);
            queue_random_traffic(RANDOM_BYTES / PHASES);
            wait_idle();
        end

        while (pending_reports.size() != 0) begin
            fail_count++;
            $display("%0t: missing report, expected event %0d, actual none",
                     $time, pending_reports.pop_front().event_code);
        end
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ----- flow_sensor_frame_parser_top.f -----
hdl/fsp_pkg.sv
hdl/fsp_front.sv
hdl/fsp_queue.sv
hdl/fsp_back.sv
hdl/flow_sensor_frame_parser_top.sv
hdl/fsp_checker.sv
tb/testbench.sv
